/* hw/rtl/u16u8_pkg.sv */
// Shared types and constants of the UTF-16 to UTF-8 validating transcoder.
package u16u8_pkg;

   localparam int unsigned MAX_UNITS_LIMIT_DEF = 4096;
   localparam int unsigned CFG_W = 13;
   localparam logic [CFG_W-1:0] MAX_UNITS_RST = 13'd4096;

   localparam int unsigned UNIT_W = 16;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CODE_W = 3;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 16;

   typedef enum logic [CODE_W-1:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_LONG  = 3'd2,
      ST_CTRL  = 3'd3,
      ST_SURR  = 3'd4
   } status_type;

endpackage

/* hw/rtl/utf16_to_utf8_validating.sv */
// Top level of the UTF-16 to UTF-8 validating transcoder.
//
//   channel   direction  tdata                                  tuser / tlast
//   req_      in         [15:0] code_unit                       tlast = end_marker
//   rsp_      out        [7:0] out_byte, [10:8] status_code,    tuser = is_status,
//                        [15:11] zero                           tlast = run_last
//   csr_      in         csr_wdata[12:0] = max_units            csr_we = write
//
// A request enters an input register and is decoded from there into a result
// register of up to four bytes, which drains one byte per cycle while rsp_tready
// is high. A code unit yields 1 to 4 output bytes, a request that yields no
// byte is consumed without a result, and an end marker yields one status byte.
// The next request is taken while the result register still drains.
// Reset is synchronous; it clears the string state and sets max_units to 4096.
// A stall on rsp_tready holds the result and, once the input register is full
// with a request that yields bytes, lowers req_tready.
module utf16_to_utf8_validating #(
   parameter int unsigned MAX_UNITS_LIMIT = u16u8_pkg::MAX_UNITS_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [u16u8_pkg::REQ_DATA_W-1:0]  req_tdata,  // [15:0] code_unit
   input  logic                              req_tlast,  // end_marker
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [u16u8_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // [7:0] out_byte,
                                                         // [10:8] status_code
   output logic                              rsp_tuser,  // is_status
   output logic                              rsp_tlast,  // run_last
   input  logic                              csr_we,
   input  logic [u16u8_pkg::CFG_W-1:0]       csr_wdata   // max_units
);

   localparam int unsigned CNT_W = $clog2(MAX_UNITS_LIMIT + 2);
   localparam int unsigned LW = (CNT_W > u16u8_pkg::CFG_W) ? CNT_W : u16u8_pkg::CFG_W;
   localparam logic [LW-1:0] LIMIT = LW'(MAX_UNITS_LIMIT);

   logic [u16u8_pkg::CFG_W-1:0]    max_units_ff;

   logic                           in_vld_ff;
   logic [u16u8_pkg::UNIT_W-1:0]   in_unit_ff;
   logic                           in_end_ff;

   logic                           high_pending_ff, high_pending_in;
   logic [9:0]                     high_payload_ff, high_payload_in;
   logic [CNT_W-1:0]               unit_count_ff, unit_count_in;
   u16u8_pkg::status_type          first_error_ff, first_error_in;

   logic [u16u8_pkg::BYTE_W-1:0]   buf_ff [4];
   logic [u16u8_pkg::BYTE_W-1:0]   buf_in [4];
   logic [2:0]                     cnt_ff, cnt_in;
   logic                           is_status_ff, is_status_in;
   u16u8_pkg::status_type          code_ff, code_in;

   logic [2:0]                     nbytes;
   logic                           buf_free;
   logic                           in_take;
   logic [LW-1:0]                  lim;
   logic [LW-1:0]                  count_ext;
   logic [20:0]                    cp;
   logic [u16u8_pkg::UNIT_W-1:0]   unit;

   assign buf_free   = (cnt_ff == 3'd0) || (rsp_tready && cnt_ff == 3'd1);
   assign in_take    = in_vld_ff && ((nbytes == 3'd0) || buf_free);
   assign req_tready = !in_vld_ff || in_take;

   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_tlast  = (cnt_ff == 3'd1);
   assign rsp_tuser  = is_status_ff;
   assign rsp_tdata  = {5'd0, code_ff, buf_ff[0]};

   always_comb begin
      unit = in_unit_ff;
      count_ext = LW'(unit_count_ff);
      lim = LW'(max_units_ff);
      if (lim == '0) begin
         lim = LW'(1);
      end else if (lim > LIMIT) begin
         lim = LIMIT;
      end

      high_pending_in = high_pending_ff;
      high_payload_in = high_payload_ff;
      unit_count_in   = unit_count_ff;
      first_error_in  = first_error_ff;
      nbytes          = 3'd0;
      is_status_in    = 1'b0;
      code_in         = u16u8_pkg::ST_OK;
      cp              = '0;
      for (int i = 0; i < 4; i++) begin
         buf_in[i] = '0;
      end

      if (in_end_ff) begin
         nbytes = 3'd1;
         is_status_in = 1'b1;
         if (unit_count_ff == '0) begin
            code_in = u16u8_pkg::ST_EMPTY;
         end else if (count_ext > lim) begin
            code_in = u16u8_pkg::ST_LONG;
         end else if (first_error_ff != u16u8_pkg::ST_OK) begin
            code_in = first_error_ff;
         end else if (high_pending_ff) begin
            code_in = u16u8_pkg::ST_SURR;
         end
         high_pending_in = 1'b0;
         high_payload_in = '0;
         unit_count_in   = '0;
         first_error_in  = u16u8_pkg::ST_OK;
      end else begin
         if (count_ext <= lim) begin
            unit_count_in = unit_count_ff + CNT_W'(1);
         end
         if (high_pending_ff) begin
            high_pending_in = 1'b0;
            high_payload_in = '0;
            if (unit[15:10] != 6'b110111) begin
               if (first_error_ff == u16u8_pkg::ST_OK) begin
                  first_error_in = u16u8_pkg::ST_SURR;
               end
            end else begin
               cp = 21'h10000 + {1'b0, high_payload_ff, unit[9:0]};
               nbytes = 3'd4;
               buf_in[0] = {5'b11110, cp[20:18]};
               buf_in[1] = {2'b10, cp[17:12]};
               buf_in[2] = {2'b10, cp[11:6]};
               buf_in[3] = {2'b10, cp[5:0]};
            end
         end else if (unit < 16'd32 || unit == 16'd127) begin
            if (first_error_ff == u16u8_pkg::ST_OK) begin
               first_error_in = u16u8_pkg::ST_CTRL;
            end
         end else if (unit[15:10] == 6'b110110) begin
            high_pending_in = 1'b1;
            high_payload_in = unit[9:0];
         end else if (unit[15:10] == 6'b110111) begin
            if (first_error_ff == u16u8_pkg::ST_OK) begin
               first_error_in = u16u8_pkg::ST_SURR;
            end
         end else if (unit < 16'h0080) begin
            nbytes = 3'd1;
            buf_in[0] = unit[7:0];
         end else if (unit < 16'h0800) begin
            nbytes = 3'd2;
            buf_in[0] = {3'b110, unit[10:6]};
            buf_in[1] = {2'b10, unit[5:0]};
         end else begin
            nbytes = 3'd3;
            buf_in[0] = {4'b1110, unit[15:12]};
            buf_in[1] = {2'b10, unit[11:6]};
            buf_in[2] = {2'b10, unit[5:0]};
         end
      end
      cnt_in = nbytes;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_units_ff <= u16u8_pkg::MAX_UNITS_RST;
      end else if (csr_we) begin
         max_units_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_unit_ff <= req_tdata[u16u8_pkg::UNIT_W-1:0];
         in_end_ff  <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_pending_ff <= 1'b0;
         high_payload_ff <= '0;
         unit_count_ff   <= '0;
         first_error_ff  <= u16u8_pkg::ST_OK;
      end else if (in_take) begin
         high_pending_ff <= high_pending_in;
         high_payload_ff <= high_payload_in;
         unit_count_ff   <= unit_count_in;
         first_error_ff  <= first_error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else if (in_take && nbytes != 3'd0) begin
         cnt_ff <= cnt_in;
      end else if (rsp_tvalid && rsp_tready) begin
         cnt_ff <= cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && nbytes != 3'd0) begin
         buf_ff       <= buf_in;
         is_status_ff <= is_status_in;
         code_ff      <= code_in;
      end else if (rsp_tvalid && rsp_tready) begin
         buf_ff[0] <= buf_ff[1];
         buf_ff[1] <= buf_ff[2];
         buf_ff[2] <= buf_ff[3];
         buf_ff[3] <= '0;
      end
   end

endmodule

/* hw/rtl/u16u8_checker.sv */
// Port-level checker of the transcoder and its bind to the top level.
module u16u8_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [u16u8_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast
);

   // A status result is always alone and carries a zero byte.
   a_status_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata[7:0] == 8'd0))
      else $error("status result malformed");

   // Data bytes carry no status code, and status codes stay in range.
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser || rsp_tdata[10:8] == u16u8_pkg::ST_OK)
                      && rsp_tdata[10:8] <= u16u8_pkg::ST_SURR
                      && rsp_tdata[15:11] == 5'd0))
      else $error("bad status code field");

   // A lead byte of a multibyte sequence is never the last byte of its run.
   a_lead_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser && rsp_tdata[7:6] == 2'b11) |-> !rsp_tlast)
      else $error("lead byte marked last");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind utf16_to_utf8_validating u16u8_checker u_u16u8_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
